// File: hdl/scrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scrb_pkg;

  localparam int NUM_REGS = 256;
  localparam int ADDR_W   = $clog2(NUM_REGS);

  typedef logic [15:0]       word_t;
  typedef logic [7:0]        idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_SET_REQ = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Register indices (word index = byte address >> 1)
  localparam idx_t IDX_DMACON  = 8'h4B;
  localparam idx_t IDX_INTENA  = 8'h4D;
  localparam idx_t IDX_INTREQ  = 8'h4E;
  localparam idx_t IDX_ADKCON  = 8'h4F;
  localparam idx_t IDX_DMACONR = 8'h01;
  localparam idx_t IDX_ADKCONR = 8'h08;
  localparam idx_t IDX_DSKBYTR = 8'h0D;
  localparam idx_t IDX_INTENAR = 8'h0E;
  localparam idx_t IDX_INTREQR = 8'h0F;
  localparam idx_t IDX_DSKLEN  = 8'h12;

  localparam word_t SET_CLR_BIT = 16'h8000;
  localparam word_t VALUE_MASK  = 16'h7FFF;
  localparam word_t NO_REG_WORD = 16'hFFFF;

  // Read aliases of the set/clear registers
  function automatic idx_t map_read(input idx_t idx);
    idx_t m;
    case (idx)
      IDX_DMACONR: m = IDX_DMACON;
      IDX_ADKCONR: m = IDX_ADKCON;
      IDX_INTENAR: m = IDX_INTENA;
      IDX_INTREQR: m = IDX_INTREQ;
      default:     m = idx;
    endcase
    return m;
  endfunction

  function automatic logic in_range(input idx_t idx);
    return {1'b0, idx} < 9'(NUM_REGS);
  endfunction

endpackage

`default_nettype wire

// File: hdl/set_clear_register_bank_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_stall  | kind, byte_address, write_data, bit_index
// out     | out_valid / out_stall| read_data, length_written
//
// One word in per cycle sustained while the output is not stalled. The accept
// edge reads the register RAM, the modify stage then updates the word, and
// the edge that frees the stage writes back and loads the output register. A
// write back in the same cycle as the next word's read of the same entry is
// forwarded. After rst a clearing pass zeroes the RAM, one entry per cycle;
// in_stall stays high until all NUM_REGS (256) entries are zero. After that it
// rises only while a finished result cannot leave the output register.

module set_clear_register_bank_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [8:0]  byte_address,
  input  wire logic [15:0] write_data,
  input  wire logic [3:0]  bit_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_data,
  output logic             length_written
);

  import scrb_pkg::*;

  // Accept side
  logic  accept;
  kind_t kind_in;
  idx_t  idx_in;
  idx_t  rd_idx;
  addr_t rd_addr;

  // Modify stage registers
  logic       busy;
  kind_t      kind_q;
  idx_t       idx_q;
  addr_t      addr_q;
  logic       range_q;
  word_t      data_q;
  logic [3:0] bit_q;
  logic       fwd;
  word_t      fwd_data;

  // Clearing pass after reset
  logic  clearing;
  addr_t clr_addr;

  // RAM write port
  logic  ram_we;
  addr_t ram_waddr;
  word_t ram_wdata;

  word_t rdata;
  word_t cur;
  word_t new_word;
  word_t result;
  logic  wr_en;
  logic  lw;
  logic  done;
  logic  wr_go;

  assign kind_in = kind_t'(kind);
  assign idx_in  = byte_address[8:1];

  always_comb begin
    case (kind_in)
      KIND_SET_REQ: rd_idx = IDX_INTREQ;
      KIND_READ:    rd_idx = map_read(idx_in);
      default:      rd_idx = idx_in;
    endcase
  end

  assign rd_addr  = rd_idx[ADDR_W-1:0];
  assign done     = !out_valid || !out_stall;
  assign in_stall = clearing || (busy && !done);
  assign accept   = in_valid && !in_stall;

  // Clearing pass owns the write port until every entry is zero
  assign ram_we    = clearing || wr_go;
  assign ram_waddr = clearing ? clr_addr : addr_q;
  assign ram_wdata = clearing ? '0 : new_word;

  scrb_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Current word: forwarded write or stored word
  assign cur = fwd ? fwd_data : rdata;

  always_comb begin
    new_word = cur;
    result   = '0;
    wr_en    = 1'b0;
    lw       = 1'b0;
    case (kind_q)
      KIND_READ: begin
        result   = range_q ? cur : NO_REG_WORD;
        new_word = cur & VALUE_MASK;  // read of DSKBYTR drops its flag
        wr_en    = range_q && (idx_q == IDX_DSKBYTR);
      end
      KIND_WRITE: begin
        if (idx_q inside {IDX_DMACON, IDX_INTENA, IDX_INTREQ, IDX_ADKCON}) begin
          if ((data_q & SET_CLR_BIT) != '0) begin
            new_word = cur | (data_q & VALUE_MASK);
          end else begin
            new_word = cur & ~data_q;
          end
        end else begin
          new_word = data_q;
        end
        wr_en  = range_q;
        result = range_q ? new_word : NO_REG_WORD;
        lw     = range_q && (idx_q == IDX_DSKLEN);
      end
      KIND_SET_REQ: begin
        new_word = cur | (word_t'(1) << bit_q);
        wr_en    = 1'b1;
        result   = new_word;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  assign wr_go = busy && done && wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + addr_t'(1);
      if (clr_addr == addr_t'(NUM_REGS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage payload; forward a write back that hits the entry being read
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind_in;
      idx_q    <= idx_in;
      addr_q   <= rd_addr;
      range_q  <= in_range(idx_in);
      data_q   <= write_data;
      bit_q    <= bit_index;
      fwd      <= wr_go && (addr_q == rd_addr);
      fwd_data <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && done) begin
      read_data      <= result;
      length_written <= lw;
    end
  end

  // A held item keeps its decode while the output is blocked
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (busy && !done) |=> (busy && $stable(kind_q) && $stable(idx_q) && $stable(addr_q)))
    else $error("stage item changed while blocked");

  // A read only writes back for the DSKBYTR flag clear
  a_read_wb: assert property (@(posedge clk) disable iff (rst)
    (wr_go && (kind_q == KIND_READ)) |-> (idx_q == IDX_DSKBYTR))
    else $error("unexpected write back on read");

  // A finished item always lands in the output register
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (busy && done) |=> out_valid)
    else $error("result lost");

endmodule

`default_nettype wire

// File: hdl/scrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
